// File: hdl/rsm_pkg.sv
// ----------------------------------------------------------------------------
// rsm_pkg - shared constants and types for the resampling voice mixer
// Widths, register indexes, saturation limits and the pipeline control word.
// ----------------------------------------------------------------------------
package rsm_pkg;

  // Fixed-point formats
  localparam int FRACTION_BITS = 14;
  localparam int GAIN_BITS     = 14;
  localparam int SAMPLE_W      = 16;
  localparam int GAIN_W        = 16;
  localparam int STEP_W        = 17;
  localparam int PHASE_W       = 18;
  localparam int ACC_W         = SAMPLE_W + GAIN_W + 2;

  // Outputs per source frame
  localparam int MAX_OUT = 16;
  localparam int COUNT_W = $clog2(MAX_OUT);

  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << FRACTION_BITS;

  // Saturation limits
  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = STEP_W;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_STEREO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_STEREO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DRY_LEFT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRY_RIGHT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_LEFT      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_RIGHT     = 3'd6;

  // Control word that travels alongside each pipeline stage
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctrl_t;

endpackage

// File: hdl/linear_resampling_voice_mixer.sv
// ----------------------------------------------------------------------------
// linear_resampling_voice_mixer - one resampling voice with dry/wet gains
//
//   channel  | direction | signals                        | content
//   ---------+-----------+--------------------------------+---------------------
//   s_*      | in        | tvalid tready tdata tuser      | source frame
//   m_*      | out       | tvalid tready tdata tlast      | mixed output sample
//   cfg_*    | in        | write index data               | register writes
//
// A frame transfers, then N samples issue, one output sample per cycle while
// m_tready does not stall (N = 0..16, set by the phase step); s_tready is low
// while the phase sequencer issues. After issue each sample passes through the
// interpolate, gain and merge stages. A stall on m_tready freezes the sequencer
// and all stages. Reset (rst, synchronous) clears the voice state bar the current
// samples, the registers to their defaults and out_valid; no clearing pass.
// ----------------------------------------------------------------------------
module linear_resampling_voice_mixer
  import rsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Source frames
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,   // [15:0] sample_left, [31:16] sample_right
  input  logic                  s_tuser,   // [0] restart
  // Output samples
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata,   // [15:0] out_left, [31:16] out_right
  output logic                  m_tlast,
  // Configuration
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [STEP_W-1:0] phase_step;
  logic              source_stereo;
  logic              output_stereo;
  logic [GAIN_W-1:0] dry_gain_left;
  logic [GAIN_W-1:0] dry_gain_right;
  logic [GAIN_W-1:0] wet_gain_left;
  logic [GAIN_W-1:0] wet_gain_right;

  // Voice state
  logic signed [SAMPLE_W-1:0] previous_left;
  logic signed [SAMPLE_W-1:0] previous_right;
  logic signed [SAMPLE_W-1:0] current_left;
  logic signed [SAMPLE_W-1:0] current_right;
  logic [PHASE_W-1:0]         phase_offset;
  logic                       have_previous;
  logic                       busy;
  logic [COUNT_W-1:0]         count;

  // Pipeline control
  stage_ctrl_t ctrl_s1;
  stage_ctrl_t ctrl_s2;
  logic        advance;
  logic        accept;

  logic signed [SAMPLE_W-1:0] in_left;
  logic signed [SAMPLE_W-1:0] in_right;
  logic [PHASE_W-1:0]         phase_sum;
  logic                       phase_past;
  logic                       issue_last;
  logic [PHASE_W-1:0]         phase_after;

  logic signed [ACC_W-1:0]    acc_left;
  logic signed [ACC_W-1:0]    acc_right;
  logic signed [SAMPLE_W-1:0] out_left;
  logic signed [SAMPLE_W-1:0] out_right;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;

  // Unpack frame; a mono source feeds both channels
  always_comb begin
    in_left  = s_tdata[15:0];
    in_right = source_stereo ? s_tdata[31:16] : s_tdata[15:0];
  end

  // Next phase and end of issue for this frame
  always_comb begin
    phase_sum   = phase_offset + PHASE_W'(phase_step);
    phase_past  = (phase_sum >= PHASE_ONE);
    issue_last  = phase_past || (count == COUNT_W'(MAX_OUT - 1));
    phase_after = phase_past ? (phase_sum - PHASE_ONE) : '0;
  end

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step     <= STEP_W'(16384);
      source_stereo  <= 1'b0;
      output_stereo  <= 1'b1;
      dry_gain_left  <= GAIN_W'(16384);
      dry_gain_right <= GAIN_W'(16384);
      wet_gain_left  <= '0;
      wet_gain_right <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_PHASE_STEP:    phase_step     <= cfg_data[STEP_W-1:0];
        CFG_SOURCE_STEREO: source_stereo  <= cfg_data[0];
        CFG_OUTPUT_STEREO: output_stereo  <= cfg_data[0];
        CFG_DRY_LEFT:      dry_gain_left  <= cfg_data[GAIN_W-1:0];
        CFG_DRY_RIGHT:     dry_gain_right <= cfg_data[GAIN_W-1:0];
        CFG_WET_LEFT:      wet_gain_left  <= cfg_data[GAIN_W-1:0];
        CFG_WET_RIGHT:     wet_gain_right <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Phase sequencer: take a frame, then issue one sample per cycle while the output advances
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_left  <= '0;
      previous_right <= '0;
      phase_offset   <= '0;
      have_previous  <= 1'b0;
      busy           <= 1'b0;
      count          <= '0;
    end else if (accept) begin
      current_left  <= in_left;
      current_right <= in_right;
      count         <= '0;
      if (s_tuser || !have_previous) begin
        // First frame or restart: store and wait
        previous_left  <= in_left;
        previous_right <= in_right;
        phase_offset   <= '0;
        have_previous  <= 1'b1;
      end else if (phase_offset >= PHASE_ONE) begin
        // Step skipped this frame entirely
        previous_left  <= in_left;
        previous_right <= in_right;
        phase_offset   <= phase_offset - PHASE_ONE;
      end else begin
        busy <= 1'b1;
      end
    end else if (busy && advance) begin
      count <= count + COUNT_W'(1);
      if (issue_last) begin
        busy           <= 1'b0;
        phase_offset   <= phase_after;
        previous_left  <= current_left;
        previous_right <= current_right;
      end else begin
        phase_offset <= phase_sum;
      end
    end
  end

  // Control words alongside the lane stages
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_s1 <= '0;
      ctrl_s2 <= '0;
    end else if (advance) begin
      ctrl_s1.valid <= busy;
      ctrl_s1.last  <= issue_last;
      ctrl_s2       <= ctrl_s1;
    end
  end

  rsm_lane u_lane_left (
    .clk         (clk),
    .advance     (advance),
    .prev_sample (previous_left),
    .cur_sample  (current_left),
    .frac        (phase_offset[FRACTION_BITS-1:0]),
    .dry_gain    (dry_gain_left),
    .wet_gain    (wet_gain_left),
    .acc         (acc_left)
  );

  rsm_lane u_lane_right (
    .clk         (clk),
    .advance     (advance),
    .prev_sample (previous_right),
    .cur_sample  (current_right),
    .frac        (phase_offset[FRACTION_BITS-1:0]),
    .dry_gain    (dry_gain_right),
    .wet_gain    (wet_gain_right),
    .acc         (acc_right)
  );

  rsm_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .ctrl          (ctrl_s2),
    .output_stereo (output_stereo),
    .acc_left      (acc_left),
    .acc_right     (acc_right),
    .out_valid     (m_tvalid),
    .out_last      (m_tlast),
    .out_left      (out_left),
    .out_right     (out_right)
  );

  assign m_tdata = {out_right, out_left};

endmodule

// File: hdl/rsm_lane.sv
// ----------------------------------------------------------------------------
// rsm_lane - one channel lane of the voice mixer
// Stage 1 interpolates between previous and current sample at the phase
// fraction; stage 2 scales the result by the summed dry and wet gains.
// ----------------------------------------------------------------------------
module rsm_lane
  import rsm_pkg::*;
(
  input  logic                       clk,
  input  logic                       advance,
  input  logic signed [SAMPLE_W-1:0] prev_sample,
  input  logic signed [SAMPLE_W-1:0] cur_sample,
  input  logic [FRACTION_BITS-1:0]   frac,
  input  logic [GAIN_W-1:0]          dry_gain,
  input  logic [GAIN_W-1:0]          wet_gain,
  output logic signed [ACC_W-1:0]    acc
);

  logic signed [SAMPLE_W:0]               diff;
  logic signed [FRACTION_BITS:0]          frac_ext;
  logic signed [SAMPLE_W+FRACTION_BITS+1:0] prod;
  logic signed [SAMPLE_W+1:0]             interp;
  logic signed [SAMPLE_W-1:0]             value;
  logic [GAIN_W:0]                        gain_sum;
  logic signed [GAIN_W+1:0]               gain_ext;

  // Floor interpolation: a + floor((b - a) * f / 2^FRACTION_BITS)
  always_comb begin
    diff     = {cur_sample[SAMPLE_W-1], cur_sample} - {prev_sample[SAMPLE_W-1], prev_sample};
    frac_ext = $signed({1'b0, frac});
    prod     = diff * frac_ext;
    interp   = {{2{prev_sample[SAMPLE_W-1]}}, prev_sample}
             + prod[SAMPLE_W+FRACTION_BITS+1:FRACTION_BITS];
  end

  // Dry and wet share one multiply: v*dry + v*wet = v*(dry + wet)
  always_comb begin
    gain_sum = {1'b0, dry_gain} + {1'b0, wet_gain};
    gain_ext = $signed({1'b0, gain_sum});
  end

  // Interpolation stage
  always_ff @(posedge clk) begin
    if (advance) begin
      value <= interp[SAMPLE_W-1:0];
    end
  end

  // Gain stage
  always_ff @(posedge clk) begin
    if (advance) begin
      acc <= value * gain_ext;
    end
  end

endmodule

// File: hdl/rsm_merge.sv
// ----------------------------------------------------------------------------
// rsm_merge - merges the two lanes into one output transfer
// Sums the lanes for mono output, rounds to nearest with ties to even,
// saturates to 16 bits and holds the result in the output register.
// ----------------------------------------------------------------------------
module rsm_merge
  import rsm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  stage_ctrl_t                ctrl,
  input  logic                       output_stereo,
  input  logic signed [ACC_W-1:0]    acc_left,
  input  logic signed [ACC_W-1:0]    acc_right,
  output logic                       out_valid,
  output logic                       out_last,
  output logic signed [SAMPLE_W-1:0] out_left,
  output logic signed [SAMPLE_W-1:0] out_right
);

  localparam int QW = ACC_W - GAIN_BITS;
  localparam logic signed [QW:0] Q_MAX = (QW+1)'(SAT_MAX);
  localparam logic signed [QW:0] Q_MIN = (QW+1)'(SAT_MIN);
  localparam logic [GAIN_BITS-1:0] HALF = GAIN_BITS'(1) << (GAIN_BITS - 1);

  function automatic logic signed [SAMPLE_W-1:0] round_sat(
    input logic signed [ACC_W-1:0] x
  );
    logic signed [QW-1:0]    q;
    logic [GAIN_BITS-1:0]    r;
    logic                    up;
    logic signed [QW:0]      qr;
    logic signed [SAMPLE_W-1:0] res;
    q  = x[ACC_W-1:GAIN_BITS];
    r  = x[GAIN_BITS-1:0];
    up = (r > HALF) || ((r == HALF) && q[0]);
    qr = $signed({q[QW-1], q}) + $signed({{QW{1'b0}}, up});
    if (qr > Q_MAX) begin
      res = SAT_MAX;
    end else if (qr < Q_MIN) begin
      res = SAT_MIN;
    end else begin
      res = qr[SAMPLE_W-1:0];
    end
    return res;
  endfunction

  logic signed [ACC_W-1:0]    mono_sum;
  logic signed [SAMPLE_W-1:0] left_next;
  logic signed [SAMPLE_W-1:0] right_next;

  // Pick stereo pair or mono sum
  always_comb begin
    mono_sum = acc_left + acc_right;
    if (output_stereo) begin
      left_next  = round_sat(acc_left);
      right_next = round_sat(acc_right);
    end else begin
      left_next  = round_sat(mono_sum);
      right_next = '0;
    end
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= ctrl.valid;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_last  <= ctrl.last;
      out_left  <= left_next;
      out_right <= right_next;
    end
  end

endmodule

// File: hdl/rsm_checker.sv
// ----------------------------------------------------------------------------
// rsm_checker - port-level checks for the resampling voice mixer
// Watches the stream and configuration ports and flags broken behaviour.
// ----------------------------------------------------------------------------
module rsm_checker
  import rsm_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [31:0]           s_tdata,
  input logic                  s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [31:0]           m_tdata,
  input logic                  m_tlast,
  input logic                  cfg_write,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  // Count output transfers since the last end-of-frame marker
  logic [COUNT_W:0] run_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_count <= '0;
    end else if (m_tvalid && m_tready) begin
      run_count <= m_tlast ? '0 : run_count + (COUNT_W+1)'(1);
    end
  end

  // Reset leaves nothing pending and the input open
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("output pending or input closed after reset");

  // A stalled output holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  // A restart frame causes no samples, so the input stays open
  a_restart_open: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> s_tready)
    else $error("restart frame closed the input");

  // No frame yields more than MAX_OUT samples
  a_run_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |-> run_count < (COUNT_W+1)'(MAX_OUT - 1))
    else $error("frame produced too many samples");

  // s_tdata and cfg_data are watched for completeness of the port view
  logic unused_ok;
  assign unused_ok = ^{s_tdata, cfg_write, cfg_index, cfg_data};

endmodule

bind linear_resampling_voice_mixer rsm_checker u_rsm_checker (.*);
